/* rtl/assert_macros.svh */
// Assertion macros shared by the RTL of the path section splitter.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define PSS_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define PSS_NEVER(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define PSS_ASSERT(lbl, clk, rst, prop, msg)
`define PSS_NEVER(lbl, clk, rst, cond, msg)
`endif
`endif

/* rtl/pss_pkg.sv */
// Types, constants and helpers for the path section splitter.
`default_nettype none
package pss_pkg;

   localparam int FRAC_BITS_DEF          = 16;
   localparam int SECTION_INDEX_BITS_DEF = 16;
   localparam int COORD_W                = 32;
   localparam int LEN_W                  = 32;
   localparam int NUM_W                  = 16;
   localparam int DIFF_W                 = 31;
   localparam int PROD_W                 = 2 * DIFF_W;
   localparam int SQ_W                   = PROD_W + 1;
   localparam int DATA_IN_W              = 2 * COORD_W;
   localparam int DATA_OUT_W             = 2 * COORD_W + NUM_W;

   localparam logic [DIFF_W-1:0] DIFF_MAX = '1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIFF,
      ST_MUL_X,
      ST_ACC_X,
      ST_MUL_Y,
      ST_ACC_Y,
      ST_ROOT,
      ST_DECIDE
   } state_type;

   function automatic logic [DIFF_W-1:0] sat_abs_diff(input logic [COORD_W-1:0] a,
                                                      input logic [COORD_W-1:0] b);
      logic signed [COORD_W:0] d;
      logic [COORD_W:0]        mag;
      d   = $signed({a[COORD_W-1], a}) - $signed({b[COORD_W-1], b});
      mag = d[COORD_W] ? (COORD_W + 1)'(-d) : (COORD_W + 1)'(d);
      return (mag > (COORD_W + 1)'(DIFF_MAX)) ? DIFF_MAX : mag[DIFF_W-1:0];
   endfunction

endpackage
`default_nettype wire

/* rtl/path_section_splitter_top.sv */
// Path section splitter: step length per point, section cut at a length bound.
// The first point of a path goes from acceptance straight to the decide step; any other point
// passes the difference step, the x and y multiply and accumulate steps and the root step, in
// which the square-root unit resolves one root bit per cycle.
// A new point is taken while the previous result still waits; the decide step holds until it leaves.
// Synchronous active-high reset clears all path state and loads the length bound with 5.0.
`default_nettype none
`include "assert_macros.svh"
module path_section_splitter_top
   import pss_pkg::*;
#(
   parameter int FRAC_BITS          = FRAC_BITS_DEF,
   parameter int SECTION_INDEX_BITS = SECTION_INDEX_BITS_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [DATA_IN_W-1:0]  req_tdata,   // point_x, point_y
   input  wire logic                  req_tlast,   // path_end
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [DATA_OUT_W-1:0]      rsp_tdata,   // out_x, out_y, section_number
   output logic                       rsp_tuser,   // section_start
   output logic                       rsp_tlast,   // path_last
   input  wire logic                  csr_wr_en,
   input  wire logic [LEN_W-1:0]      csr_wr_data
);

   localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(64'(5) << FRAC_BITS);
   localparam logic [SECTION_INDEX_BITS-1:0] CNT_MAX = '1;

   state_type state_ff, state_in;

   logic                          open_ff;
   logic [COORD_W-1:0]            prev_x_ff, prev_y_ff;
   logic [LEN_W-1:0]              acc_ff, acc_in;
   logic [SECTION_INDEX_BITS-1:0] cnt_ff, cnt_in;
   logic [LEN_W-1:0]              len_ff;

   logic [COORD_W-1:0]            x_ff, y_ff;
   logic                          last_ff;
   logic [DIFF_W-1:0]             ax_ff, ay_ff, mul_op;
   logic [PROD_W-1:0]             prod_ff, prod_in;
   logic [SQ_W-1:0]               sum_ff;
   logic [SQ_W-1:0]               rem_ff, rem_in;
   logic [SQ_W-1:0]               root_ff, root_in;
   logic [SQ_W-1:0]               bit_ff;
   logic [SQ_W:0]                 trial;

   logic [LEN_W:0]                total;
   logic                          over;
   logic                          start_in;
   logic [NUM_W-1:0]              num_sat;

   logic                          rsp_valid_ff;
   logic [COORD_W-1:0]            rsp_x_ff, rsp_y_ff;
   logic [NUM_W-1:0]              rsp_num_ff;
   logic                          rsp_start_ff, rsp_last_ff;

   logic                          accept;
   logic                          commit;

   assign accept = req_tvalid && req_tready;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = open_ff ? ST_DIFF : ST_DECIDE;
            end
         end
         ST_DIFF:   state_in = ST_MUL_X;
         ST_MUL_X:  state_in = ST_ACC_X;
         ST_ACC_X:  state_in = ST_MUL_Y;
         ST_MUL_Y:  state_in = ST_ACC_Y;
         ST_ACC_Y:  state_in = ST_ROOT;
         ST_ROOT: begin
            if (bit_ff[0]) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            if (commit) begin
               state_in = ST_IDLE;
            end
         end
         default:   state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_tready = 1'b0;
      commit     = 1'b0;
      mul_op     = ax_ff;
      case (state_ff)
         ST_IDLE:   req_tready = 1'b1;
         ST_MUL_Y:  mul_op     = ay_ff;
         ST_DECIDE: commit     = !rsp_valid_ff || rsp_tready;
         default:   mul_op     = ax_ff;
      endcase
   end

   assign prod_in = PROD_W'(mul_op) * PROD_W'(mul_op);

   always_comb begin
      trial = {1'b0, root_ff} + {1'b0, bit_ff};
      if ({1'b0, rem_ff} >= trial) begin
         rem_in  = rem_ff - trial[SQ_W-1:0];
         root_in = (root_ff >> 1) + bit_ff;
      end else begin
         rem_in  = rem_ff;
         root_in = root_ff >> 1;
      end
   end

   always_comb begin
      total    = {1'b0, acc_ff} + {1'b0, root_ff[LEN_W-1:0]};
      over     = total > {1'b0, len_ff};
      start_in = !open_ff || over;
      acc_in   = start_in ? '0 : total[LEN_W-1:0];
      cnt_in   = cnt_ff;
      if (open_ff && over && cnt_ff != CNT_MAX) begin
         cnt_in = cnt_ff + 1'b1;
      end
   end

   generate
      if (SECTION_INDEX_BITS > NUM_W) begin : g_num_wide
         assign num_sat = (|cnt_in[SECTION_INDEX_BITS-1:NUM_W]) ? '1 : cnt_in[NUM_W-1:0];
      end else begin : g_num_narrow
         assign num_sat = NUM_W'(cnt_in);
      end
   endgenerate

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         open_ff      <= 1'b0;
         prev_x_ff    <= '0;
         prev_y_ff    <= '0;
         acc_ff       <= '0;
         cnt_ff       <= '0;
         len_ff       <= LEN_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_wr_en) begin
            len_ff <= csr_wr_data;
         end
         if (commit) begin
            if (last_ff) begin
               open_ff   <= 1'b0;
               prev_x_ff <= '0;
               prev_y_ff <= '0;
               acc_ff    <= '0;
               cnt_ff    <= '0;
            end else begin
               open_ff   <= 1'b1;
               prev_x_ff <= x_ff;
               prev_y_ff <= y_ff;
               acc_ff    <= acc_in;
               cnt_ff    <= cnt_in;
            end
         end
         if (commit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         x_ff    <= req_tdata[COORD_W-1:0];
         y_ff    <= req_tdata[DATA_IN_W-1:COORD_W];
         last_ff <= req_tlast;
      end
      case (state_ff)
         ST_DIFF: begin
            ax_ff <= sat_abs_diff(x_ff, prev_x_ff);
            ay_ff <= sat_abs_diff(y_ff, prev_y_ff);
         end
         ST_MUL_X: prod_ff <= prod_in;
         ST_ACC_X: sum_ff  <= {1'b0, prod_ff};
         ST_MUL_Y: prod_ff <= prod_in;
         ST_ACC_Y: begin
            rem_ff  <= sum_ff + {1'b0, prod_ff};
            root_ff <= '0;
            bit_ff  <= {1'b1, {(SQ_W - 1){1'b0}}};
         end
         ST_ROOT: begin
            rem_ff  <= rem_in;
            root_ff <= root_in;
            bit_ff  <= bit_ff >> 2;
         end
         default: begin
         end
      endcase
      if (commit) begin
         rsp_x_ff     <= x_ff;
         rsp_y_ff     <= y_ff;
         rsp_num_ff   <= num_sat;
         rsp_start_ff <= start_in;
         rsp_last_ff  <= last_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_num_ff, rsp_y_ff, rsp_x_ff};
   assign rsp_tuser  = rsp_start_ff;
   assign rsp_tlast  = rsp_last_ff;

   `PSS_ASSERT(a_first_point_skips_root, clock, reset,
      (accept && !open_ff) |=> (state_ff == ST_DECIDE), "first point must skip the step")
   `PSS_ASSERT(a_root_bit_onehot, clock, reset,
      (state_ff == ST_ROOT) |-> $onehot(bit_ff), "root trial bit lost its single set bit")
   `PSS_ASSERT(a_counter_moves_on_commit, clock, reset,
      !commit |=> $stable(cnt_ff), "section counter changed outside a commit")
   `PSS_ASSERT(a_path_end_closes, clock, reset,
      (commit && last_ff) |=> (!open_ff && cnt_ff == '0), "path end did not clear state")

endmodule
`default_nettype wire

/* sim/path_section_checker.sv */
// Checker for the path section splitter: predicts the section tags of each point and compares.
module path_section_checker
   import pss_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   input  wire logic                  req_tready,
   input  wire logic [DATA_IN_W-1:0]  req_tdata,
   input  wire logic                  req_tlast,
   input  wire logic                  rsp_tvalid,
   input  wire logic                  rsp_tready,
   input  wire logic [DATA_OUT_W-1:0] rsp_tdata,
   input  wire logic                  rsp_tuser,
   input  wire logic                  rsp_tlast,
   input  wire logic                  csr_wr_en,
   input  wire logic [LEN_W-1:0]      csr_wr_data,
   output int                         fail_count,
   output int                         points_in_flight
);

   typedef struct packed {
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
      logic               start;
      logic [NUM_W-1:0]   number;
      logic               last;
   } section_point_type;

   section_point_type  pending_points[$];
   logic [LEN_W-1:0]   length_limit;
   logic               path_open;
   logic [COORD_W-1:0] prev_px;
   logic [COORD_W-1:0] prev_py;
   logic [LEN_W-1:0]   travelled;
   logic [NUM_W-1:0]   section_count;

   initial begin
      fail_count       = 0;
      points_in_flight = 0;
   end

   function automatic logic [DIFF_W-1:0] clipped_gap(input logic [COORD_W-1:0] a,
                                                     input logic [COORD_W-1:0] b);
      logic signed [COORD_W:0] d;
      d = $signed({a[COORD_W-1], a}) - $signed({b[COORD_W-1], b});
      if (d < 0)
         d = -d;
      if (d > $signed({2'b00, {DIFF_W{1'b1}}}))
         return '1;
      return d[DIFF_W-1:0];
   endfunction

   function automatic logic [LEN_W-1:0] floor_root(input logic [63:0] v);
      logic [63:0] rem;
      logic [63:0] root;
      logic [63:0] probe;
      rem   = v;
      root  = '0;
      probe = 64'h4000_0000_0000_0000;
      while (probe > rem)
         probe = probe >> 2;
      while (probe != 0) begin
         if (rem >= root + probe) begin
            rem  = rem - (root + probe);
            root = (root >> 1) + probe;
         end else begin
            root = root >> 1;
         end
         probe = probe >> 2;
      end
      return root[LEN_W-1:0];
   endfunction

   function automatic void clear_path();
      path_open     = 1'b0;
      prev_px       = '0;
      prev_py       = '0;
      travelled     = '0;
      section_count = '0;
   endfunction

   function automatic void advance_path(input logic [COORD_W-1:0] x,
                                        input logic [COORD_W-1:0] y,
                                        input logic               last);
      section_point_type p;
      logic [DIFF_W-1:0] gx;
      logic [DIFF_W-1:0] gy;
      logic [63:0]       sq;
      logic [LEN_W-1:0]  step;
      logic [LEN_W:0]    reach;
      p.start = 1'b0;
      if (!path_open) begin
         p.start   = 1'b1;
         path_open = 1'b1;
         travelled = '0;
      end else begin
         gx    = clipped_gap(x, prev_px);
         gy    = clipped_gap(y, prev_py);
         sq    = 64'(gx) * 64'(gx) + 64'(gy) * 64'(gy);
         step  = floor_root(sq);
         reach = {1'b0, travelled} + {1'b0, step};
         if (reach > {1'b0, length_limit}) begin
            p.start   = 1'b1;
            travelled = '0;
            if (section_count != '1)
               section_count = section_count + 1'b1;
         end else begin
            travelled = reach[LEN_W-1:0];
         end
      end
      prev_px  = x;
      prev_py  = y;
      p.x      = x;
      p.y      = y;
      p.number = section_count;
      p.last   = last;
      pending_points.insert(pending_points.size(), p);
      if (last)
         clear_path();
   endfunction

   function automatic void log_failure(input string what, input section_point_type want,
                                       input section_point_type got);
      string head;
      string tail;
      fail_count++;
      if (fail_count <= 10) begin
         head = $sformatf("%0s: expected x=%h y=%h start=%b number=%0d last=%b", what,
                          want.x, want.y, want.start, want.number, want.last);
         tail = $sformatf("got x=%h y=%h start=%b number=%0d last=%b",
                          got.x, got.y, got.start, got.number, got.last);
         $display("%0s, %0s", head, tail);
      end
   endfunction

   always @(posedge clock) begin
      section_point_type seen;
      section_point_type want;
      if (reset) begin
         clear_path();
         length_limit = LEN_W'(5) << FRAC_BITS_DEF;
         pending_points.delete();
      end else begin
         if (csr_wr_en)
            length_limit = csr_wr_data;
         if (rsp_tvalid && rsp_tready) begin
            seen.x      = rsp_tdata[COORD_W-1:0];
            seen.y      = rsp_tdata[2*COORD_W-1:COORD_W];
            seen.number = rsp_tdata[DATA_OUT_W-1:2*COORD_W];
            seen.start  = rsp_tuser;
            seen.last   = rsp_tlast;
            if (pending_points.size() == 0) begin
               log_failure("unexpected transaction", '0, seen);
            end else begin
               want = pending_points.pop_front();
               if (seen.x !== want.x || seen.y !== want.y || seen.start !== want.start ||
                   seen.number !== want.number || seen.last !== want.last)
                  log_failure("mismatch", want, seen);
            end
         end
         if (req_tvalid && req_tready)
            advance_path(req_tdata[COORD_W-1:0], req_tdata[DATA_IN_W-1:COORD_W], req_tlast);
      end
      points_in_flight <= pending_points.size();
   end

endmodule

/* sim/tb.sv */
// Testbench top for the path section splitter: clock, reset, stimulus and verdict.
module tb;
   import pss_pkg::*;

   localparam int CYCLE_LIMIT  = 600000;
   localparam int HOLD_CYCLES  = 600;
   localparam int DRAIN_CYCLES = 40;
   localparam int PHASE_POINTS = 128;
   localparam int LAST_PHASE   = 7;

   logic                  clock       = 1'b0;
   logic                  reset       = 1'b1;
   logic                  req_tvalid  = 1'b0;
   logic                  req_tready;
   logic [DATA_IN_W-1:0]  req_tdata   = '0;
   logic                  req_tlast   = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready  = 1'b0;
   logic [DATA_OUT_W-1:0] rsp_tdata;
   logic                  rsp_tuser;
   logic                  rsp_tlast;
   logic                  csr_wr_en   = 1'b0;
   logic [LEN_W-1:0]      csr_wr_data = '0;

   int fail_count;
   int points_in_flight;
   int cycle_count = 0;
   bit quiet       = 1'b0;
   bit hold_go     = 1'b0;
   bit hold_taken  = 1'b0;
   int hold_left   = 0;
   int stall_left  = 0;
   int stall_odds  = 8;
   int gap_odds    = 6;

   always #4 clock = ~clock;

   path_section_splitter_top uut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   path_section_checker section_check (
      .clock            (clock),
      .reset            (reset),
      .req_tvalid       (req_tvalid),
      .req_tready       (req_tready),
      .req_tdata        (req_tdata),
      .req_tlast        (req_tlast),
      .rsp_tvalid       (rsp_tvalid),
      .rsp_tready       (rsp_tready),
      .rsp_tdata        (rsp_tdata),
      .rsp_tuser        (rsp_tuser),
      .rsp_tlast        (rsp_tlast),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .fail_count       (fail_count),
      .points_in_flight (points_in_flight)
   );

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("path_section_splitter_top verification failed");
         $finish;
      end
   end

   // hold off the result side: one long stretch on request, random bursts otherwise
   always @(negedge clock) begin
      if (hold_go && !hold_taken) begin
         hold_taken = 1'b1;
         hold_left  = HOLD_CYCLES;
      end
      if (cycle_count % 256 == 0) begin
         case ($urandom_range(0, 2))
            0: stall_odds = 0;
            1: stall_odds = 10;
            default: stall_odds = 3;
         endcase
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else if (!quiet && stall_odds != 0 && $urandom_range(0, stall_odds - 1) == 0) begin
         stall_left = $urandom_range(0, 13);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   task automatic send_point(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
                             input logic last);
      int gap;
      if (!quiet && gap_odds != 0 && $urandom_range(0, gap_odds - 1) == 0) begin
         gap = $urandom_range(1, 14);
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {y, x};
      req_tlast  <= last;
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      @(negedge clock);
   endtask

   task automatic set_section_length(input logic [LEN_W-1:0] value);
      req_tvalid <= 1'b0;
      while (points_in_flight != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   function automatic logic [COORD_W-1:0] jitter(input int unsigned span);
      return COORD_W'($urandom_range(0, 2 * span)) - COORD_W'(span);
   endfunction

   task automatic walk_path(output int sent);
      int               len;
      int               mode;
      int unsigned      span;
      logic [COORD_W-1:0] px;
      logic [COORD_W-1:0] py;
      len  = ($urandom_range(0, 9) == 0) ? 1 : $urandom_range(2, 30);
      mode = $urandom_range(0, 9);
      case (mode)
         2, 3, 4: span = 32'h0001_FFFF;
         5, 6, 7: span = 32'h0007_FFFF;
         8:       span = 32'h0000_00FF;
         default: span = 32'h0FFF_FFFF;
      endcase
      case ($urandom_range(0, 2))
         0: gap_odds = 0;
         1: gap_odds = 12;
         default: gap_odds = 3;
      endcase
      px = $urandom;
      py = $urandom;
      for (int k = 0; k < len; k++) begin
         if (k > 0) begin
            if (mode < 2) begin
               px = $urandom;
               py = $urandom;
            end else if ($urandom_range(0, 9) != 0) begin
               px = px + jitter(span);
               py = py + jitter(span);
            end
         end
         send_point(px, py, k == len - 1);
      end
      sent = len;
   endtask

   initial begin
      int               phase_count;
      int               sent;
      logic [LEN_W-1:0] limit_value;
      repeat (3) @(negedge clock);
      reset <= 1'b0;

      send_point(32'h0000_0000, 32'h0000_0000, 1'b0);
      send_point(32'h0003_0000, 32'h0000_0000, 1'b0);
      send_point(32'h0003_0000, 32'h0004_0000, 1'b0);
      send_point(32'h0003_0000, 32'h0004_0000, 1'b0);
      send_point(32'h0006_0000, 32'h0008_0000, 1'b0);
      send_point(32'h0006_0000, 32'h0008_0000, 1'b0);
      send_point(32'h0006_0001, 32'h0008_0000, 1'b0);
      send_point(32'h8000_0000, 32'h8000_0000, 1'b0);
      send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);
      send_point(32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
      send_point(32'h8000_0000, 32'h7FFF_FFFF, 1'b1);
      send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1);
      send_point(32'h0000_0000, 32'h0000_0000, 1'b1);
      send_point(32'h8000_0000, 32'h0000_0000, 1'b0);
      send_point(32'h8000_0000, 32'h0000_0000, 1'b0);
      send_point(32'h7FFF_FFFF, 32'h0000_0000, 1'b0);
      send_point(32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b0);
      send_point(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
      send_point(32'h0000_0001, 32'h0000_0001, 1'b1);

      for (int phase = 1; phase <= LAST_PHASE; phase++) begin
         case (phase)
            1: limit_value = '0;
            2: limit_value = '1;
            3: limit_value = LEN_W'(1) << FRAC_BITS_DEF;
            4: limit_value = $urandom_range(32'h0001_0000, 32'h0014_0000);
            5: limit_value = $urandom;
            6: limit_value = $urandom_range(0, 32'h0001_0000);
            default: limit_value = LEN_W'(5) << FRAC_BITS_DEF;
         endcase
         set_section_length(limit_value);
         if (phase == LAST_PHASE)
            quiet = 1'b1;
         if (phase == 3)
            hold_go = 1'b1;
         phase_count = 0;
         while (phase_count < PHASE_POINTS) begin
            walk_path(sent);
            phase_count += sent;
         end
      end

      req_tvalid <= 1'b0;
      while (points_in_flight != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (fail_count == 0 && points_in_flight == 0)
         $display("path_section_splitter_top verification clean");
      else
         $display("path_section_splitter_top verification failed");
      $finish;
   end

endmodule

/* filelist.f */
+incdir+rtl
rtl/pss_pkg.sv
rtl/path_section_splitter_top.sv
sim/path_section_checker.sv
sim/tb.sv
